// ===== rtl/macc_pkg.sv =====
// ----------------------------------------------------------------------------
// macc_pkg
// Shared widths, opcodes, status codes and types of the accumulator CPU.
// ----------------------------------------------------------------------------
package macc_pkg;

   localparam int ADDR_W    = 12;
   localparam int DATA_W    = 16;
   localparam int MEM_WORDS = 4096;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   // Addresses at or above this limit read as zero and ignore writes.
   localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_WORDS);

   localparam logic [ADDR_W-1:0] SKIP_NEG  = 12'h000;
   localparam logic [ADDR_W-1:0] SKIP_ZERO = 12'h400;
   localparam logic [ADDR_W-1:0] SKIP_POS  = 12'h800;

   typedef enum logic [3:0] {
      OP_JNS     = 4'h0,
      OP_LOAD    = 4'h1,
      OP_STORE   = 4'h2,
      OP_ADD     = 4'h3,
      OP_SUBT    = 4'h4,
      OP_INPUT   = 4'h5,
      OP_OUTPUT  = 4'h6,
      OP_HALT    = 4'h7,
      OP_SKIP    = 4'h8,
      OP_JUMP    = 4'h9,
      OP_CLEAR   = 4'ha,
      OP_ADDI    = 4'hb,
      OP_JUMPI   = 4'hc,
      OP_STOREI  = 4'hd,
      OP_LOADI   = 4'he,
      OP_ILLEGAL = 4'hf
   } op_type;

   typedef enum logic [1:0] {
      ST_RUN     = 2'd0,
      ST_HALTED  = 2'd1,
      ST_ILLEGAL = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] acc;
      logic [ADDR_W-1:0] pc;
      status_type        status;
      logic              out_valid;
      logic [DATA_W-1:0] out_value;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
   } exec_result_type;

   // Instructions that read MEM[x] before they can complete.
   function automatic logic needs_operand(op_type op);
      logic r;
      case (op) inside
         OP_LOAD, OP_ADD, OP_SUBT, OP_ADDI, OP_JUMPI, OP_STOREI, OP_LOADI: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Instructions that read a second time through the pointer in MEM[x].
   function automatic logic needs_indirect(op_type op);
      logic r;
      case (op) inside
         OP_ADDI, OP_LOADI: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/macc_ram.sv =====
// ----------------------------------------------------------------------------
// macc_ram
// Main memory: one write port and one read port with registered read data.
// Addresses beyond the populated range read as zero and drop writes.
// ----------------------------------------------------------------------------
module macc_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [macc_pkg::ADDR_W-1:0] wr_addr,
   input  logic [macc_pkg::DATA_W-1:0] wr_data,
   input  logic [macc_pkg::ADDR_W-1:0] rd_addr,
   output logic [macc_pkg::DATA_W-1:0] rd_data
);
   import macc_pkg::*;

   logic [DATA_W-1:0] mem [MEM_WORDS];
   logic [DATA_W-1:0] q_ff;
   logic              oob_ff;
   logic              wr_ok;
   logic              rd_ok;

   assign wr_ok = wr_en && ({1'b0, wr_addr} < MEM_LIMIT);
   assign rd_ok = {1'b0, rd_addr} < MEM_LIMIT;

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr[MEM_AW-1:0]] <= wr_data;
      end
      q_ff   <= mem[rd_addr[MEM_AW-1:0]];
      oob_ff <= !rd_ok;
   end

   assign rd_data = oob_ff ? '0 : q_ff;

endmodule

// ===== rtl/macc_exec.sv =====
// ----------------------------------------------------------------------------
// macc_exec
// Instruction execute: computes the new AC, PC, status, Output value and the
// memory write of one instruction once its operand is at hand.
// ----------------------------------------------------------------------------
module macc_exec (
   input  macc_pkg::op_type            op,
   input  logic [macc_pkg::ADDR_W-1:0] x,
   input  logic [macc_pkg::DATA_W-1:0] acc,
   input  logic [macc_pkg::ADDR_W-1:0] pc,
   input  logic [macc_pkg::DATA_W-1:0] operand,
   input  logic [macc_pkg::DATA_W-1:0] in_data,
   output macc_pkg::exec_result_type   res
);
   import macc_pkg::*;

   logic [ADDR_W-1:0] pc_inc;
   logic [ADDR_W-1:0] pc_skip;
   logic              neg;
   logic              zero;
   logic              skip;

   assign pc_inc  = pc + ADDR_W'(1);
   assign pc_skip = pc + ADDR_W'(2);
   assign neg     = acc[DATA_W-1];
   assign zero    = (acc == '0);

   always_comb begin
      case (x)
         SKIP_NEG:  skip = neg;
         SKIP_ZERO: skip = zero;
         SKIP_POS:  skip = !neg && !zero;
         default:   skip = 1'b0;
      endcase
   end

   always_comb begin
      res           = '0;
      res.acc       = acc;
      res.pc        = pc_inc;
      res.status    = ST_RUN;
      res.wr_addr   = x;
      res.wr_data   = acc;
      unique case (op)
         OP_JNS: begin
            res.wr_en   = 1'b1;
            res.wr_data = DATA_W'(pc_inc);
            res.pc      = x + ADDR_W'(1);
         end
         OP_LOAD:   res.acc = operand;
         OP_STORE:  res.wr_en = 1'b1;
         OP_ADD:    res.acc = acc + operand;
         OP_SUBT:   res.acc = acc - operand;
         OP_INPUT:  res.acc = in_data;
         OP_OUTPUT: begin
            res.out_valid = 1'b1;
            res.out_value = acc;
         end
         OP_HALT: begin
            res.status = ST_HALTED;
            res.pc     = pc;
         end
         OP_SKIP:   res.pc = skip ? pc_skip : pc_inc;
         OP_JUMP:   res.pc = x;
         OP_CLEAR:  res.acc = '0;
         OP_ADDI:   res.acc = acc + operand;
         OP_JUMPI:  res.pc = operand[ADDR_W-1:0];
         OP_STOREI: begin
            res.wr_en   = 1'b1;
            res.wr_addr = operand[ADDR_W-1:0];
         end
         OP_LOADI:  res.acc = operand;
         OP_ILLEGAL: begin
            res.status = ST_ILLEGAL;
            res.pc     = pc;
         end
         default: res.status = ST_ILLEGAL;
      endcase
   end

endmodule

// ===== rtl/marie_accumulator_cpu_unit.sv =====
// ----------------------------------------------------------------------------
// marie_accumulator_cpu_unit
// 16-bit accumulator CPU around one synchronous main memory. Each item either
// loads a program word or, while running, executes the instruction at PC.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_mode, req_address, req_data
//   rsp      out        rsp_valid, rsp_stall, rsp_program_counter,
//                       rsp_accumulator, rsp_output_valid,
//                       rsp_output_value, rsp_run_status
//
// A program write completes in S_READY; an instruction without a memory operand
// steps through S_READY and S_FETCH, a direct memory instruction also through
// S_OPER and an indirect one through S_IND as well; the dependent reads of the
// single memory read port set these steps. The input buffer takes a new item
// only in the cycle after it empties, never in the cycle it passes one on.
// After reset a clearing pass writes zero to all 4096 words; items are held
// off until it ends.
// An input buffer and an output register let the next item enter while a
// result waits on rsp_stall.
// ----------------------------------------------------------------------------
module marie_accumulator_cpu_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [macc_pkg::ADDR_W-1:0]        req_address,
   input  logic [macc_pkg::DATA_W-1:0]        req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [macc_pkg::ADDR_W-1:0]        rsp_program_counter,
   output logic signed [macc_pkg::DATA_W-1:0] rsp_accumulator,
   output logic                               rsp_output_valid,
   output logic [macc_pkg::DATA_W-1:0]        rsp_output_value,
   output logic [1:0]                         rsp_run_status
);
   import macc_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_READY,
      S_FETCH,
      S_OPER,
      S_IND
   } state_type;

   state_type         state_ff, state_in;
   logic [MEM_AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic              buf_full_ff, buf_full_in;
   logic              buf_mode_ff, buf_mode_in;
   logic [ADDR_W-1:0] buf_addr_ff, buf_addr_in;
   logic [DATA_W-1:0] buf_data_ff, buf_data_in;

   logic [DATA_W-1:0] in_data_ff, in_data_in;
   logic [DATA_W-1:0] ir_ff, ir_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   status_type        stop_ff, stop_in;
   logic              ov_valid_ff, ov_valid_in;
   logic [DATA_W-1:0] ov_value_ff, ov_value_in;
   logic              pend_ff, pend_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_pc_ff, rsp_pc_in;
   logic [DATA_W-1:0] rsp_acc_ff, rsp_acc_in;
   logic              rsp_ov_ff, rsp_ov_in;
   logic [DATA_W-1:0] rsp_val_ff, rsp_val_in;
   status_type        rsp_st_ff, rsp_st_in;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   logic [DATA_W-1:0] instr;
   op_type            op;
   logic [ADDR_W-1:0] op_x;
   exec_result_type   ex;

   logic              out_free;
   logic              load_out;
   logic              can_go;
   logic              finish;

   macc_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The instruction word arrives from memory in the fetch cycle and is held
   // in ir_ff for the later operand cycles.
   assign instr = (state_ff == S_FETCH) ? mem_rd_data : ir_ff;
   assign op    = op_type'(instr[DATA_W-1:DATA_W-4]);
   assign op_x  = instr[ADDR_W-1:0];

   macc_exec u_exec (
      .op      (op),
      .x       (op_x),
      .acc     (acc_ff),
      .pc      (pc_ff),
      .operand (mem_rd_data),
      .in_data (in_data_ff),
      .res     (ex)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = pend_ff && out_free;
   assign can_go   = !pend_ff || out_free;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      buf_full_in  = buf_full_ff;
      buf_mode_in  = buf_mode_ff;
      buf_addr_in  = buf_addr_ff;
      buf_data_in  = buf_data_ff;
      in_data_in   = in_data_ff;
      ir_in        = ir_ff;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      stop_in      = stop_ff;
      ov_valid_in  = ov_valid_ff;
      ov_value_in  = ov_value_ff;
      pend_in      = pend_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = buf_addr_ff;
      mem_wr_data  = buf_data_ff;
      mem_rd_addr  = pc_ff;
      finish       = 1'b0;

      if (req_valid && !buf_full_ff) begin
         buf_full_in = 1'b1;
         buf_mode_in = req_mode;
         buf_addr_in = req_address;
         buf_data_in = req_data;
      end

      if (load_out) begin
         pend_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ADDR_W'(clr_cnt_ff);
            mem_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + MEM_AW'(1);
            if (clr_cnt_ff == MEM_AW'(MEM_WORDS - 1)) begin
               state_in = S_READY;
            end
         end
         S_READY: begin
            if (can_go && buf_full_ff) begin
               buf_full_in = 1'b0;
               in_data_in  = buf_data_ff;
               if (!buf_mode_ff) begin
                  mem_wr_en   = 1'b1;
                  ov_valid_in = 1'b0;
                  ov_value_in = '0;
                  pend_in     = 1'b1;
               end else if (stop_ff != ST_RUN) begin
                  ov_valid_in = 1'b0;
                  ov_value_in = '0;
                  pend_in     = 1'b1;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            ir_in = mem_rd_data;
            if (needs_operand(op)) begin
               mem_rd_addr = op_x;
               state_in    = S_OPER;
            end else begin
               finish = 1'b1;
            end
         end
         S_OPER: begin
            if (needs_indirect(op)) begin
               mem_rd_addr = mem_rd_data[ADDR_W-1:0];
               state_in    = S_IND;
            end else begin
               finish = 1'b1;
            end
         end
         S_IND: begin
            finish = 1'b1;
         end
         default: state_in = S_READY;
      endcase

      if (finish) begin
         pc_in       = ex.pc;
         acc_in      = ex.acc;
         stop_in     = ex.status;
         ov_valid_in = ex.out_valid;
         ov_value_in = ex.out_value;
         mem_wr_en   = ex.wr_en;
         mem_wr_addr = ex.wr_addr;
         mem_wr_data = ex.wr_data;
         pend_in     = 1'b1;
         state_in    = S_READY;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pc_in    = rsp_pc_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_ov_in    = rsp_ov_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_pc_in    = pc_ff;
         rsp_acc_in   = acc_ff;
         rsp_ov_in    = ov_valid_ff;
         rsp_val_in   = ov_value_ff;
         rsp_st_in    = stop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         buf_full_ff  <= 1'b0;
         pc_ff        <= '0;
         acc_ff       <= '0;
         stop_ff      <= ST_RUN;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         buf_full_ff  <= buf_full_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         stop_ff      <= stop_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      buf_mode_ff <= buf_mode_in;
      buf_addr_ff <= buf_addr_in;
      buf_data_ff <= buf_data_in;
      in_data_ff  <= in_data_in;
      ir_ff       <= ir_in;
      ov_valid_ff <= ov_valid_in;
      ov_value_ff <= ov_value_in;
      rsp_pc_ff   <= rsp_pc_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_ov_ff   <= rsp_ov_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign req_stall           = buf_full_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_accumulator     = rsp_acc_ff;
   assign rsp_output_valid    = rsp_ov_ff;
   assign rsp_output_value    = rsp_val_ff;
   assign rsp_run_status      = rsp_st_ff;

endmodule
